### rtl/afsk_pkg.sv
// ----------------------------------------------------------------------------
// AFSK modulator package
// Shared constants, register codes, interface types and the sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package afsk_pkg;

    // Sine table geometry: the phase word is cut to TABLE_ADDR_BITS address bits.
    localparam int TABLE_ADDR_BITS = 12;
    localparam int PHASE_W         = 32;
    localparam int QTR_W           = TABLE_ADDR_BITS - 2;
    localparam int QUARTER         = 1 << QTR_W;
    // Quarter-wave table holds QUARTER + 1 entries, so its index needs one extra bit.
    localparam int LUT_IDX_W       = QTR_W + 1;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W - 1;
    localparam int RATE_W     = 18;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_INC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_INC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_RATE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd3;

    // Register reset values.
    localparam logic [PHASE_W-1:0] RST_LOW_INC     = 32'd89478485;
    localparam logic [PHASE_W-1:0] RST_HIGH_INC    = 32'd214748365;
    localparam logic [RATE_W-1:0]  RST_BIT_RATE    = 18'd1200;
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE = 18'd48000;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;
    localparam int          TAYLOR_TERMS = 13;

    // Side information that travels with one table lookup.
    typedef struct packed {
        logic negate;
        logic bit_value;
        logic byte_done;
    } t_lookup;

    typedef logic [MAG_W-1:0] t_sine_lut [0:QUARTER];

    // Product of two unsigned Q2.62 numbers, truncated back to Q2.62.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Taylor series sine for an angle in [0, pi/2], Q2.62 in and out.
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // First-quadrant magnitudes round(sin(pi/2 * k / QUARTER) * 32767), evaluated
    // once at elaboration.
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut    lut;
        logic [63:0]  kk;
        logic [63:0]  x;
        logic [63:0]  s;
        logic [127:0] scaled;
        logic [63:0]  v;
        for (int k = 0; k <= QUARTER; k++) begin
            kk = 64'(k);
            x  = (HALF_PI_Q62 >> QTR_W) * kk
               + (((HALF_PI_Q62 & 64'(QUARTER - 1)) * kk) >> QTR_W);
            s  = sine_q62(x);
            scaled = {64'd0, s} * {64'd0, FULL_SCALE} + (128'd1 << 61);
            v = scaled[125:62];
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            lut[k] = v[MAG_W-1:0];
        end
        return lut;
    endfunction

endpackage

`default_nettype wire

### rtl/afsk_sine_rom.sv
// ----------------------------------------------------------------------------
// AFSK sine table
// Synchronous quarter-wave sine magnitude ROM; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module afsk_sine_rom (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [afsk_pkg::LUT_IDX_W-1:0] i_addr,
    output logic      [afsk_pkg::MAG_W-1:0]     o_data
);
    import afsk_pkg::*;

    localparam t_sine_lut SINE_LUT = build_sine_lut();

    logic [MAG_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= SINE_LUT[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/afsk_ctrl.sv
// ----------------------------------------------------------------------------
// AFSK modulator control
// Configuration registers, phase accumulator and bit timing; forms the table
// address and sign for each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module afsk_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [afsk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [afsk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_step,
    input  wire logic [afsk_pkg::BYTE_W-1:0]     i_data_byte,
    output logic      [afsk_pkg::LUT_IDX_W-1:0]  o_rom_addr,
    output afsk_pkg::t_lookup                    o_lookup
);
    import afsk_pkg::*;

    logic [PHASE_W-1:0]   r_low_inc;
    logic [PHASE_W-1:0]   r_high_inc;
    logic [RATE_W-1:0]    r_bit_rate;
    logic [RATE_W-1:0]    r_sample_rate;
    logic [PHASE_W-1:0]   r_phase_acc;
    logic [RATE_W-1:0]    r_bit_timer;
    logic [BIT_IDX_W-1:0] r_bit_index;

    logic [PHASE_W-1:0]         n_phase_acc;
    logic [RATE_W-1:0]          n_bit_timer;
    logic [BIT_IDX_W-1:0]       n_bit_index;
    logic                       cur_bit;
    logic [RATE_W-1:0]          sr;
    logic [RATE_W-1:0]          br;
    logic [RATE_W:0]            t_sum;
    logic [RATE_W:0]            t_diff;
    logic                       bit_end;
    logic [TABLE_ADDR_BITS-1:0] tbl_addr;
    logic [QTR_W-1:0]           tbl_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_inc     <= RST_LOW_INC;
            r_high_inc    <= RST_HIGH_INC;
            r_bit_rate    <= RST_BIT_RATE;
            r_sample_rate <= RST_SAMPLE_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_INC:     r_low_inc     <= i_cfg_data[PHASE_W-1:0];
                REG_HIGH_INC:    r_high_inc    <= i_cfg_data[PHASE_W-1:0];
                REG_BIT_RATE:    r_bit_rate    <= i_cfg_data[RATE_W-1:0];
                REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Bits go out MSB first, so bit position 7 - index is the inverted index.
    assign cur_bit     = i_data_byte[~r_bit_index];
    assign n_phase_acc = r_phase_acc + (cur_bit ? r_high_inc : r_low_inc);

    assign sr = (r_sample_rate == '0) ? RATE_W'(1) : r_sample_rate;
    assign br = (r_bit_rate > sr) ? sr : r_bit_rate;

    assign t_sum   = {1'b0, r_bit_timer} + {1'b0, br};
    assign bit_end = (t_sum >= {1'b0, sr});
    assign t_diff  = t_sum - {1'b0, sr};

    // A timer left over from a larger sample rate is clamped just below the modulus.
    always_comb begin
        n_bit_timer = t_sum[RATE_W-1:0];
        n_bit_index = r_bit_index;
        if (bit_end) begin
            n_bit_index = r_bit_index + BIT_IDX_W'(1);
            if (t_diff >= {1'b0, sr}) begin
                n_bit_timer = sr - RATE_W'(1);
            end else begin
                n_bit_timer = t_diff[RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_bit_timer <= '0;
            r_bit_index <= '0;
        end else if (i_step) begin
            r_phase_acc <= n_phase_acc;
            r_bit_timer <= n_bit_timer;
            r_bit_index <= n_bit_index;
        end
    end

    // The top address bit is inverted; the two quadrant bits then pick sign and mirror.
    assign tbl_addr = n_phase_acc[PHASE_W-1 -: TABLE_ADDR_BITS]
                    ^ {1'b1, {(TABLE_ADDR_BITS-1){1'b0}}};
    assign tbl_off  = tbl_addr[QTR_W-1:0];

    assign o_rom_addr = tbl_addr[QTR_W] ? (LUT_IDX_W'(QUARTER) - {1'b0, tbl_off})
                                        : {1'b0, tbl_off};

    assign o_lookup.negate    = tbl_addr[TABLE_ADDR_BITS-1];
    assign o_lookup.bit_value = cur_bit;
    assign o_lookup.byte_done = bit_end && (r_bit_index == {BIT_IDX_W{1'b1}});

    a_done_wraps_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_lookup.byte_done) |=> (r_bit_index == '0))
        else $error("byte end did not return the bit index to the MSB");

    a_timer_below_modulus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_bit_timer < $past(sr)))
        else $error("bit timer left at or above the sample rate");

    a_idle_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase_acc) && $stable(r_bit_index))
        else $error("state changed without a sample step");

endmodule

`default_nettype wire

### rtl/afsk_dds_modulator_top.sv
// ----------------------------------------------------------------------------
// AFSK DDS modulator
// Binary FSK modulator: one sine sample per input byte tick, bits sent MSB first.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     i_valid / o_ready      i_data_byte[7:0]
//  output    o_valid / i_ready      o_sample[15:0] (signed), o_bit_value, o_byte_done
//  config    i_cfg_we               i_cfg_idx[1:0], i_cfg_data[31:0]
//
// One item per cycle sustained while the sink keeps i_ready high; each sample passes
// through the registered read of the sine table and then the output register.
// Synchronous active-low reset clears the phase, bit timer, bit index, the
// pipeline valid flags and reloads the register defaults; no clearing pass.
// An output stall backs up into the table read stage before o_ready drops, so
// two results can be held while the sink waits.
// ----------------------------------------------------------------------------
`default_nettype none

module afsk_dds_modulator_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [afsk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [afsk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [afsk_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [afsk_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_bit_value,
    output logic                                 o_byte_done
);
    import afsk_pkg::*;

    logic                  step;
    logic [LUT_IDX_W-1:0]  rom_addr;
    t_lookup               lookup;
    logic [MAG_W-1:0]      rom_data;

    logic                  r_s1_valid;
    t_lookup               r_s1_info;
    logic                  s1_advance;

    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_bit_value;
    logic                  r_byte_done;
    logic [SAMPLE_W-1:0]   n_sample;

    // Stage 1 moves on when the output register is empty or being drained.
    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign step       = i_valid && o_ready;

    afsk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_data_byte (i_data_byte),
        .o_rom_addr  (rom_addr),
        .o_lookup    (lookup)
    );

    afsk_sine_rom u_rom (
        .i_clk   (i_clk),
        .i_rd_en (step),
        .i_addr  (rom_addr),
        .o_data  (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (step) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s1_info <= lookup;
        end
    end

    assign n_sample = r_s1_info.negate ? (SAMPLE_W'(0) - {1'b0, rom_data})
                                       : {1'b0, rom_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_sample    <= n_sample;
            r_bit_value <= r_s1_info.bit_value;
            r_byte_done <= r_s1_info.byte_done;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;
    assign o_bit_value = r_bit_value;
    assign o_byte_done = r_byte_done;

    a_step_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_s1_valid)
        else $error("accepted item did not reach the table read stage");

    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> r_s1_valid && $stable(rom_data)
                                        && $stable(r_s1_info))
        else $error("stalled table read stage lost its data");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("output became valid without a table read in flight");

endmodule

`default_nettype wire

### bench/afsk_dds_modulator_top_test.sv
// ----------------------------------------------------------------------------
// AFSK DDS modulator testbench
// Sends byte ticks through the modulator under changing register settings and
// random handshake gaps. A scoreboard predicts every sample from its own
// phase accumulator, bit timer and sine table, and checks each output transfer.
// ----------------------------------------------------------------------------

module afsk_dds_modulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ADDR_BITS    = afsk_pkg::TABLE_ADDR_BITS;
    localparam int          ROM_SIZE     = 1 << ADDR_BITS;
    localparam int          RANDOM_TICKS = 700;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [63:0] HALF_PI      = 64'h6487ED5110B4611A;
    localparam logic [63:0] SCALE        = 64'd32767;

    typedef struct {
        logic [15:0] sample;
        logic        bit_value;
        logic        byte_done;
    } t_sample_item;

    class afsk_scoreboard;
        logic [31:0]   space_step;
        logic [31:0]   mark_step;
        logic [17:0]   baud;
        logic [17:0]   fs;
        logic [31:0]   phase;
        logic [17:0]   bit_timer;
        logic [2:0]    bit_pos;
        logic [15:0]   sine_rom [0:ROM_SIZE-1];
        t_sample_item  expected_samples [$];
        int            mismatches;
        int            ticks;
        int            checked;
        int            bytes_sent;

        function new();
            for (int a = 0; a < ROM_SIZE; a++) begin
                sine_rom[a] = rom_entry(a);
            end
            space_step = afsk_pkg::RST_LOW_INC;
            mark_step  = afsk_pkg::RST_HIGH_INC;
            baud       = afsk_pkg::RST_BIT_RATE;
            fs         = afsk_pkg::RST_SAMPLE_RATE;
            phase      = '0;
            bit_timer  = '0;
            bit_pos    = '0;
            mismatches = 0;
            ticks      = 0;
            checked    = 0;
            bytes_sent = 0;
        endfunction

        // Unsigned Q2.62 product, truncated.
        function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = 128'(a) * 128'(b);
            return p[125:62];
        endfunction

        function logic [63:0] fx_sine(logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] sum;
            x2   = fx_mul(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 13; n++) begin
                term = fx_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            return sum;
        endfunction

        // Full-wave entry built from the first quadrant by symmetry.
        function logic [15:0] rom_entry(int unsigned addr);
            int unsigned  sh;
            logic [1:0]   quad;
            logic [63:0]  quarter;
            logic [63:0]  r;
            logic [63:0]  k;
            logic [63:0]  x;
            logic [63:0]  s;
            logic [63:0]  v;
            logic [127:0] p;
            sh      = ADDR_BITS - 2;
            quarter = 64'd1 << sh;
            quad    = 2'((addr >> sh) & 3);
            r       = 64'(addr) & (quarter - 1);
            k       = quad[0] ? quarter - r : r;
            x       = (HALF_PI >> sh) * k + (((HALF_PI & (quarter - 1)) * k) >> sh);
            s       = fx_sine(x);
            p       = 128'(s) * 128'(SCALE) + (128'd1 << 61);
            v       = p[125:62];
            if (v > SCALE) begin
                v = SCALE;
            end
            return quad[1] ? 16'(-v) : 16'(v);
        endfunction

        function void set_reg(logic [afsk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                afsk_pkg::REG_LOW_INC:     space_step = data;
                afsk_pkg::REG_HIGH_INC:    mark_step  = data;
                afsk_pkg::REG_BIT_RATE:    baud       = data[17:0];
                afsk_pkg::REG_SAMPLE_RATE: fs         = data[17:0];
                default: ;
            endcase
        endfunction

        // Advances the modulator state by one accepted tick and queues its sample.
        function t_sample_item note_tick(logic [7:0] data_byte);
            t_sample_item item;
            int unsigned  sr;
            int unsigned  br;
            int unsigned  t;
            int unsigned  addr;
            logic         bit_v;
            sr    = (fs == 0) ? 1 : fs;
            br    = (baud > sr) ? sr : baud;
            bit_v = data_byte[3'd7 - bit_pos];
            phase = phase + (bit_v ? mark_step : space_step);
            addr  = (phase >> (32 - ADDR_BITS)) ^ (1 << (ADDR_BITS - 1));
            item.sample    = sine_rom[addr];
            item.bit_value = bit_v;
            item.byte_done = 1'b0;
            t = bit_timer + br;
            if (t >= sr) begin
                t = t - sr;
                // A timer left over from a larger modulus is clamped.
                if (t >= sr) begin
                    t = sr - 1;
                end
                item.byte_done = (bit_pos == 3'd7);
                bit_pos = bit_pos + 3'd1;
            end
            bit_timer = t[17:0];
            expected_samples.push_back(item);
            ticks++;
            if (item.byte_done) begin
                bytes_sent++;
            end
            return item;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_sample(logic [15:0] sample, logic bit_value, logic byte_done);
            t_sample_item want;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with no pending tick", $signed(sample)));
            end else begin
                want = expected_samples.pop_front();
                checked++;
                if (sample !== want.sample) begin
                    report_mismatch($sformatf("result %0d sample %0d, expected %0d", checked,
                        $signed(sample), $signed(want.sample)));
                end
                if (bit_value !== want.bit_value) begin
                    report_mismatch($sformatf("result %0d bit_value %b, expected %b", checked,
                        bit_value, want.bit_value));
                end
                if (byte_done !== want.byte_done) begin
                    report_mismatch($sformatf("result %0d byte_done %b, expected %b", checked,
                        byte_done, want.byte_done));
                end
            end
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [afsk_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [afsk_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [afsk_pkg::BYTE_W-1:0]     i_data_byte = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic signed [afsk_pkg::SAMPLE_W-1:0] o_sample;
    logic                            o_bit_value;
    logic                            o_byte_done;

    afsk_scoreboard sb = new();
    int             results_seen = 0;
    int             settings_used = 0;

    afsk_dds_modulator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .o_bit_value (o_bit_value),
        .o_byte_done (o_byte_done)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_sample(o_sample, o_bit_value, o_byte_done);
            results_seen++;
        end
    end

    // Sink: random ready pattern, with one long hold-off that backs up the pipeline.
    initial begin : sink
        int unsigned r;
        int unsigned n;
        bit          held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                i_ready <= 1'b0;
                n = HOLD_CYCLES;
            end else if (r < 50) begin
                i_ready <= 1'b1;
                n = $urandom_range(1, 30);
            end else if (r < 85) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 3);
            end else if (r < 95) begin
                i_ready <= 1'b1;
                n = $urandom_range(40, 100);
            end else begin
                i_ready <= 1'b0;
                n = $urandom_range(10, 40);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("afsk_dds_modulator_top_test NOT OK");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'd0;
        end else if (r == 1) begin
            return 32'hFFFF_FFFF;
        end else if (r < 5) begin
            return $urandom_range(1, 32'h0100_0000);
        end
        return $urandom;
    endfunction

    // Offers one tick and waits for its transfer; returns whether it closed a byte.
    task automatic send_tick(input logic [7:0] data_byte, output logic done);
        t_sample_item item;
        i_valid     <= 1'b1;
        i_data_byte <= data_byte;
        do @(posedge i_clk); while (!o_ready);
        item = sb.note_tick(data_byte);
        done = item.byte_done;
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = pick_gap();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted sample has been checked.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [afsk_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [31:0] space, input logic [31:0] mark,
                                input logic [31:0] baud, input logic [31:0] rate);
        write_reg(afsk_pkg::REG_LOW_INC, space);
        write_reg(afsk_pkg::REG_HIGH_INC, mark);
        write_reg(afsk_pkg::REG_BIT_RATE, baud);
        write_reg(afsk_pkg::REG_SAMPLE_RATE, rate);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic pick_rates(output logic [31:0] baud, output logic [31:0] rate);
        int unsigned r;
        int unsigned sr;
        int unsigned br;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            sr = $urandom_range(1, 16);
            br = $urandom_range(1, sr + 4);
        end else if (r < 88) begin
            sr = $urandom_range(1000, 18'h3FFFF);
            br = sr / $urandom_range(1, 8) + $urandom_range(0, 3);
        end else begin
            case ($urandom_range(0, 3))
                0: sr = 0;
                1: sr = 1;
                2: sr = 200000;
                default: sr = 18'h3FFFF;
            endcase
            case ($urandom_range(0, 2))
                0: br = 0;
                1: br = 1;
                default: br = 18'h3FFFF;
            endcase
        end
        // Bits above the register width are ignored by the block.
        baud = {14'($urandom_range(0, 16'h3FFF)), 18'(br)};
        rate = {14'($urandom_range(0, 16'h3FFF)), 18'(sr)};
    endtask

    initial begin : stimulus
        logic [7:0]  data_byte;
        logic [31:0] baud;
        logic [31:0] rate;
        logic        done;
        int          random_ticks;
        int          phase_ticks;
        int          phase_len;
        int          noise_at;
        int          byte_ticks;

        random_ticks = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults straight out of reset.
        repeat (4) send_tick(8'h80, done);

        // Wrapping phase steps, zero sample rate and a saturated bit rate: one
        // sample per bit, with a leftover timer from the default setting.
        drain();
        program_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        foreach (sb.sine_rom[i]) begin
            if (i < 8) begin
                send_tick(8'hA5, done);
            end
        end
        send_tick(8'h5A, done);

        // Zero bit rate: the bit never ends.
        drain();
        program_regs(32'h8000_0000, 32'h0000_0001, 32'd0, 32'd200000);
        repeat (3) send_tick(8'h00, done);
        send_tick(8'hFF, done);

        // Build up a large timer, then shrink the modulus under it.
        drain();
        program_regs(32'h1234_5678, 32'h0FED_CBA9, 32'd999, 32'd1000);
        repeat (4) send_tick(8'h3C, done);
        drain();
        program_regs(32'h0555_5555, 32'h0CCC_CCCD, 32'd3, 32'd3);
        repeat (3) send_tick(8'hC3, done);

        while (random_ticks < RANDOM_TICKS) begin
            drain();
            pick_rates(baud, rate);
            program_regs(pick_step(), pick_step(), baud, rate);
            phase_len   = $urandom_range(40, 120);
            phase_ticks = 0;
            while (phase_ticks < phase_len) begin
                // Mostly whole bytes held until byte_done; sometimes the byte
                // changes in the middle.
                data_byte  = 8'($urandom);
                noise_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : -1;
                byte_ticks = 0;
                done       = 1'b0;
                while (!done && phase_ticks < phase_len) begin
                    if (byte_ticks == noise_at) begin
                        data_byte = 8'($urandom);
                    end
                    send_tick(data_byte, done);
                    byte_ticks++;
                    phase_ticks++;
                    random_ticks++;
                    sender_gap();
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks, checked %0d samples, %0d bytes completed, %0d settings.",
            sb.ticks, sb.checked, sb.bytes_sent, settings_used);
        $display("Settings spanned zero and full phase steps, zero and saturated bit rates, %s",
            "zero sample rate and a stale bit timer.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("afsk_dds_modulator_top_test OK");
        end else begin
            $display("afsk_dds_modulator_top_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/afsk_pkg.sv
rtl/afsk_sine_rom.sv
rtl/afsk_ctrl.sv
rtl/afsk_dds_modulator_top.sv
bench/afsk_dds_modulator_top_test.sv
